[rtl/asfd_pkg.sv]
// Package for the array sample frame deframer.
// Holds payload structs, state encoding and frame layout constants; no dependencies.
package asfd_pkg;

  localparam int unsigned FIFO_DEPTH_DEF   = 4096;
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned FRAME_BYTES_DEF  = 2048;

  localparam logic [7:0] TYPE_HI = 8'hCD;
  localparam logic [7:0] TYPE_LO = 8'hBF;
  localparam logic [7:0] GAP_WRAP = 8'd255;

  localparam int unsigned POS_TYPE_HI  = 12;
  localparam int unsigned POS_TYPE_LO  = 13;
  localparam int unsigned POS_CHANNELS = 14;
  localparam int unsigned POS_SNAP_HI  = 15;
  localparam int unsigned POS_SNAP_LO  = 16;
  localparam int unsigned POS_SAMPLES  = 17;
  localparam int unsigned STRIDE_WIDE   = 32;
  localparam int unsigned STRIDE_NARROW = 16;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_WIDE = 3'd0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic               sample_valid;
    logic [2:0]         channel;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic               snapshot_end;
    logic               frame_done;
    logic               frame_accepted;
    logic               gap_detected;
    logic [7:0]         lost_frames;
    logic [12:0]        stored_snapshots;
    logic [15:0]        rx_error_count;
    logic               fifo_full;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP,
    ST_HDR_F,
    ST_HDR_U,
    ST_MUL,
    ST_CPOS,
    ST_CNT_F,
    ST_CNT_U,
    ST_HOLD_F,
    ST_HOLD_U,
    ST_TOTAL,
    ST_FILL_SET,
    ST_FILL,
    ST_SNAP,
    ST_SMP_F,
    ST_SMP_U,
    ST_EMIT
  } state_e;

endpackage

[rtl/array_sample_frame_deframer_core.sv]
// Top level of the array sample frame deframer: frame buffer, decoder and sample FIFO.
// Depends on asfd_pkg.
//
// channel | direction | handshake                       | payload
// --------+-----------+---------------------------------+-----------------
// input   | in        | start & !busy                   | in_i  (in_t)
// result  | out       | res_valid_o, one cycle, no hold | res_o (res_t)
// config  | in        | APB write, pready tied high     | wide_samples
//
// A plain push or a pop on an empty FIFO: result next cycle, next beat accepted at once.
// A pop: one sample store read. A frame end: header walk, counter read, a fetch and
// an update state per frame byte, a fill state per fill sample, on both memory ports.
// After reset a clearing pass writes zero to each sample store entry
// (32768 at the defaults) while busy is high.
// The receiver cannot stall: each result beat is shown once.
module array_sample_frame_deframer_core #(
  parameter int unsigned FIFO_DEPTH   = asfd_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned NUM_CHANNELS = asfd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned FRAME_BYTES  = asfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  asfd_pkg::in_t               in_i,
  output logic                        res_valid_o,
  output asfd_pkg::res_t              res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asfd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import asfd_pkg::*;

  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned NCH_W  = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned ROW_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FB_W   = $clog2(FRAME_BYTES);
  localparam int unsigned LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned SS_AW  = ROW_W + CH_W;
  localparam int unsigned SS_DEPTH = 1 << SS_AW;
  localparam int unsigned PTR_W  = 26;

  state_e state_q, state_d;

  logic [7:0]       fs_mem [FRAME_BYTES];
  logic [7:0]       fs_rdata_q;
  logic             fs_ok_q;
  logic [31:0]      ss_mem [SS_DEPTH];
  logic [31:0]      ss_rdata_q;
  logic             fs_we;
  logic             ss_we;
  logic [SS_AW-1:0] ss_waddr;
  logic [SS_AW-1:0] ss_raddr;
  logic [31:0]      ss_wdata;

  logic [SS_AW-1:0] clr_q, clr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             wide_q, wide_d;
  logic             first_q, first_d;
  logic [7:0]       prev_q, prev_d;
  logic [15:0]      err_q, err_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0] wr_q, wr_d;
  logic [ROW_W-1:0] rd_q, rd_d;
  logic [CH_W-1:0]  rch_q, rch_d;
  logic [31:0]      held_q [NUM_CHANNELS];
  logic [31:0]      held_d [NUM_CHANNELS];

  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [PTR_W-1:0] base_q, base_d;
  logic [7:0]       raw_q, raw_d;
  logic [NCH_W-1:0] nch_q, nch_d;
  logic [15:0]      snaps_q, snaps_d;
  logic [15:0]      s_q, s_d;
  logic [NCH_W-1:0] ch_q, ch_d;
  logic [1:0]       bi_q, bi_d;
  logic [23:0]      sreg_q, sreg_d;
  logic [23:0]      prod_q, prod_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             acc_q, acc_d;
  logic             gap_q, gap_d;
  logic [7:0]       miss_q, miss_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic [7:0]       byte_v;
  logic             hdr_reject;
  logic             ch_last;
  logic             smp_last;
  logic             gap_cond;
  logic [CNT_W-1:0] room;
  logic             fill_over;
  logic [CNT_W-1:0] fill_k;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W-1:0] wr_next;
  logic [ROW_W-1:0] rd_next;
  logic [PTR_W-1:0] stride;
  logic [31:0]      smp_word;
  logic [8:0]       ctr_p1;

  assign accept   = start && !busy;
  assign byte_v   = fs_ok_q ? fs_rdata_q : 8'h00;
  assign hdr_reject = ((ptr_q == PTR_W'(POS_TYPE_HI)) && (byte_v != TYPE_HI)) ||
                      ((ptr_q == PTR_W'(POS_TYPE_LO)) && (byte_v != TYPE_LO));
  assign ch_last  = (ch_q + NCH_W'(1)) == nch_q;
  assign smp_last = wide_q ? (bi_q == 2'd3) : (bi_q == 2'd1);
  assign ctr_p1   = {1'b0, byte_v} + 9'd1;
  assign gap_cond = ({1'b0, prev_q} > ctr_p1) && ((prev_q - byte_v) != GAP_WRAP);
  assign room     = CNT_W'(FIFO_DEPTH) - cnt_q;
  assign fill_over = {8'h00, prod_q} > 32'(room);
  assign fill_k   = fill_over ? room : CNT_W'(prod_q);
  assign last_row = (wr_q == '0) ? ROW_W'(FIFO_DEPTH - 1) : wr_q - ROW_W'(1);
  assign wr_next  = (wr_q == ROW_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + ROW_W'(1);
  assign rd_next  = (rd_q == ROW_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + ROW_W'(1);
  assign stride   = wide_q ? PTR_W'(STRIDE_WIDE) : PTR_W'(STRIDE_NARROW);
  assign smp_word = wide_q ? {sreg_q, byte_v}
                           : {{8{sreg_q[7]}}, sreg_q[7:0], {8{byte_v[7]}}, byte_v};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SS_AW'(SS_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_POP) begin
            if (cnt_q != '0) state_d = ST_POP;
          end else if (in_i.frame_end) begin
            state_d = ST_HDR_F;
          end
        end
      end
      ST_POP:    state_d = ST_IDLE;
      ST_HDR_F:  state_d = ST_HDR_U;
      ST_HDR_U: begin
        if (hdr_reject) state_d = ST_EMIT;
        else if (ptr_q == PTR_W'(POS_SNAP_LO)) state_d = ST_MUL;
        else state_d = ST_HDR_F;
      end
      ST_MUL:    state_d = ST_CPOS;
      ST_CPOS:   state_d = ST_CNT_F;
      ST_CNT_F:  state_d = ST_CNT_U;
      ST_CNT_U: begin
        if (!first_q && gap_cond) state_d = (nch_q == '0) ? ST_TOTAL : ST_HOLD_F;
        else state_d = ST_SNAP;
      end
      ST_HOLD_F: state_d = ST_HOLD_U;
      ST_HOLD_U: state_d = ch_last ? ST_TOTAL : ST_HOLD_F;
      ST_TOTAL:  state_d = ST_FILL_SET;
      ST_FILL_SET: state_d = (fill_k == '0) ? ST_SNAP : ST_FILL;
      ST_FILL: begin
        if (((nch_q == '0) || ch_last) && (fill_q == CNT_W'(1))) state_d = ST_SNAP;
      end
      ST_SNAP: begin
        priority if (s_q == snaps_q) state_d = ST_EMIT;
        else if (cnt_q >= CNT_W'(FIFO_DEPTH)) state_d = ST_EMIT;
        else if (nch_q != '0) state_d = ST_SMP_F;
      end
      ST_SMP_F:  state_d = ST_SMP_U;
      ST_SMP_U: begin
        if (smp_last && ch_last) state_d = ST_SNAP;
        else state_d = ST_SMP_F;
      end
      ST_EMIT:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_d = clr_q;   len_d = len_q;     wide_d = wide_q;  first_d = first_q;
    prev_d = prev_q; err_d = err_q;     full_d = full_q;  cnt_d = cnt_q;
    wr_d = wr_q;     rd_d = rd_q;       rch_d = rch_q;    held_d = held_q;
    ptr_d = ptr_q;   base_d = base_q;   raw_d = raw_q;    nch_d = nch_q;
    snaps_d = snaps_q; s_d = s_q;       ch_d = ch_q;      bi_d = bi_q;
    sreg_d = sreg_q; prod_d = prod_q;   fill_d = fill_q;  acc_d = acc_q;
    gap_d = gap_q;   miss_d = miss_q;   res_d = res_q;    res_valid_d = 1'b0;
    fs_we = 1'b0;
    ss_we = 1'b0;
    ss_waddr = {wr_q, ch_q[CH_W-1:0]};
    ss_wdata = smp_word;
    ss_raddr = {rd_q, rch_q};

    if (psel && penable && pwrite && pready && (paddr == ADDR_WIDE)) wide_d = pwdata[0];

    unique case (state_q)
      ST_CLEAR: begin
        ss_we = 1'b1;
        ss_waddr = clr_q;
        ss_wdata = '0;
        clr_d = clr_q + SS_AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          res_d.stored_snapshots = 13'(cnt_q);
          res_d.rx_error_count = err_q;
          res_d.fifo_full = full_q;
          if (in_i.opcode == OP_PUSH) begin
            if (len_q < LEN_W'(FRAME_BYTES)) begin
              fs_we = 1'b1;
              len_d = len_q + LEN_W'(1);
            end
            if (in_i.frame_end) begin
              ptr_d = PTR_W'(POS_TYPE_HI);
              acc_d = 1'b0;
              gap_d = 1'b0;
              miss_d = '0;
            end else begin
              res_valid_d = 1'b1;
            end
          end else if (cnt_q == '0) begin
            res_valid_d = 1'b1;
          end
        end
      end
      ST_POP: begin
        res_d = '0;
        res_d.sample_valid = 1'b1;
        res_d.channel = 3'(rch_q);
        res_d.sample_real = ss_rdata_q[15:0];
        res_d.sample_imag = ss_rdata_q[31:16];
        if (rch_q == CH_W'(NUM_CHANNELS - 1)) begin
          res_d.snapshot_end = 1'b1;
          rch_d = '0;
          rd_d = rd_next;
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          rch_d = rch_q + CH_W'(1);
        end
        res_d.stored_snapshots = 13'(cnt_d);
        res_d.rx_error_count = err_q;
        res_d.fifo_full = full_q;
        res_valid_d = 1'b1;
      end
      ST_HDR_F: ;
      ST_HDR_U: begin
        ptr_d = ptr_q + PTR_W'(1);
        if (ptr_q == PTR_W'(POS_TYPE_LO)) acc_d = !hdr_reject;
        if (ptr_q == PTR_W'(POS_CHANNELS)) begin
          raw_d = byte_v;
          nch_d = (byte_v > 8'(NUM_CHANNELS)) ? NCH_W'(NUM_CHANNELS) : NCH_W'(byte_v);
        end
        if (ptr_q == PTR_W'(POS_SNAP_HI)) snaps_d[15:8] = byte_v;
        if (ptr_q == PTR_W'(POS_SNAP_LO)) snaps_d[7:0] = byte_v;
      end
      ST_MUL:  prod_d = snaps_q * raw_q;
      ST_CPOS: ptr_d = PTR_W'(POS_SAMPLES) + PTR_W'({prod_q, 1'b0});
      ST_CNT_F: ;
      ST_CNT_U: begin
        prev_d = byte_v;
        s_d = '0;
        base_d = PTR_W'(POS_SAMPLES);
        ch_d = '0;
        if (first_q) begin
          first_d = 1'b0;
        end else if (gap_cond) begin
          gap_d = 1'b1;
          miss_d = prev_q - byte_v;
          if (err_q != 16'hFFFF) err_d = err_q + 16'd1;
        end
      end
      ST_HOLD_F: ss_raddr = {last_row, ch_q[CH_W-1:0]};
      ST_HOLD_U: begin
        held_d[ch_q[CH_W-1:0]] = ss_rdata_q;
        ch_d = ch_last ? '0 : ch_q + NCH_W'(1);
      end
      ST_TOTAL: prod_d = snaps_q * miss_q;
      ST_FILL_SET: begin
        fill_d = fill_k;
        ch_d = '0;
        if (fill_over) full_d = 1'b1;
        else if (fill_k != '0) full_d = 1'b0;
      end
      ST_FILL: begin
        if (nch_q != '0) begin
          ss_we = 1'b1;
          ss_wdata = held_q[ch_q[CH_W-1:0]];
        end
        if ((nch_q == '0) || ch_last) begin
          ch_d = '0;
          wr_d = wr_next;
          cnt_d = cnt_q + CNT_W'(1);
          fill_d = fill_q - CNT_W'(1);
        end else begin
          ch_d = ch_q + NCH_W'(1);
        end
      end
      ST_SNAP: begin
        priority if (s_q == snaps_q) begin
        end else if (cnt_q >= CNT_W'(FIFO_DEPTH)) begin
          full_d = 1'b1;
        end else if (nch_q == '0) begin
          wr_d = wr_next;
          cnt_d = cnt_q + CNT_W'(1);
          full_d = 1'b0;
          s_d = s_q + 16'd1;
        end else begin
          ptr_d = base_q;
          ch_d = '0;
          bi_d = '0;
        end
      end
      ST_SMP_F: ;
      ST_SMP_U: begin
        sreg_d = {sreg_q[15:0], byte_v};
        ptr_d = ptr_q + PTR_W'(1);
        bi_d = bi_q + 2'd1;
        if (smp_last) begin
          ss_we = 1'b1;
          bi_d = '0;
          if (ch_last) begin
            ch_d = '0;
            wr_d = wr_next;
            cnt_d = cnt_q + CNT_W'(1);
            full_d = 1'b0;
            s_d = s_q + 16'd1;
            base_d = base_q + stride;
          end else begin
            ch_d = ch_q + NCH_W'(1);
          end
        end
      end
      ST_EMIT: begin
        res_d = '0;
        res_d.frame_done = 1'b1;
        res_d.frame_accepted = acc_q;
        res_d.gap_detected = gap_q;
        res_d.lost_frames = miss_q;
        res_d.stored_snapshots = 13'(cnt_q);
        res_d.rx_error_count = err_q;
        res_d.fifo_full = full_q;
        res_valid_d = 1'b1;
        len_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      len_q <= '0;
      wide_q <= 1'b1;
      first_q <= 1'b1;
      prev_q <= '0;
      err_q <= '0;
      full_q <= 1'b0;
      cnt_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
      rch_q <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) held_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      len_q <= len_d;
      wide_q <= wide_d;
      first_q <= first_d;
      prev_q <= prev_d;
      err_q <= err_d;
      full_q <= full_d;
      cnt_q <= cnt_d;
      wr_q <= wr_d;
      rd_q <= rd_d;
      rch_q <= rch_d;
      res_valid_q <= res_valid_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    base_q <= base_d;
    raw_q <= raw_d;
    nch_q <= nch_d;
    snaps_q <= snaps_d;
    s_q <= s_d;
    ch_q <= ch_d;
    bi_q <= bi_d;
    sreg_q <= sreg_d;
    prod_q <= prod_d;
    fill_q <= fill_d;
    acc_q <= acc_d;
    gap_q <= gap_d;
    miss_q <= miss_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[len_q[FB_W-1:0]] <= in_i.frame_byte;
    fs_rdata_q <= fs_mem[ptr_q[FB_W-1:0]];
    fs_ok_q <= ptr_q < PTR_W'(len_q);
  end

  always_ff @(posedge clk_i) begin
    if (ss_we) ss_mem[ss_waddr] <= ss_wdata;
    ss_rdata_q <= ss_mem[ss_raddr];
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == ADDR_WIDE) ? {31'h0, wide_q} : 32'h0;

endmodule

[rtl/asfd_checker.sv]
// Port-level checker for the array sample frame deframer, bound to its top level.
// Depends on asfd_pkg and array_sample_frame_deframer_core.
module asfd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input asfd_pkg::in_t  in_i,
  input logic           res_valid_o,
  input asfd_pkg::res_t res_o
);
  import asfd_pkg::*;

  // plain push beat answers in the next cycle with no frame status
  a_push_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_i.opcode == OP_PUSH) && !in_i.frame_end
    |=> res_valid_o && !res_o.frame_done && !res_o.sample_valid)
    else $error("plain push beat not answered next cycle");

  a_pop_vs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.sample_valid |-> !res_o.frame_done)
    else $error("sample and frame status in one beat");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.frame_accepted || res_o.gap_detected) |-> res_o.frame_done &&
      res_o.frame_accepted)
    else $error("frame status without frame end");

  a_gap_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.gap_detected |-> (res_o.lost_frames != 8'd0) &&
      (res_o.rx_error_count != 16'd0))
    else $error("gap reported without count");

  a_err_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o) |-> res_o.rx_error_count >= $past(res_o.rx_error_count))
    else $error("error count went down");

endmodule

bind array_sample_frame_deframer_core asfd_checker u_asfd_checker (.*);
